### src/piecewise_linear_table_eval_assert.svh
// Assertion macros for the piecewise-linear table evaluator checker.
`ifndef PIECEWISE_LINEAR_TABLE_EVAL_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_EVAL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plte check failed");

// Next-cycle implication, disabled during reset.
`define PLTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plte check failed");

`endif

### src/plte_pkg.sv
// Shared types and constants for the piecewise-linear table evaluator.
package plte_pkg;

  localparam int DATA_W         = 32;
  localparam int COUNT_W        = 5;
  localparam int IDX_W          = 4;
  localparam int STATUS_W       = 2;
  localparam int MAX_POINTS_DEF = 16;
  localparam int CNT_W          = 7;
  localparam int MUL_STEPS      = 32;
  localparam int DIV_STEPS      = 64;

  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd2;
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FEW   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd2;
  localparam logic                KIND_LOAD    = 1'b0;
  localparam logic                KIND_EVAL    = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic             accept;
    logic             scan;
    logic             prep;
    logic             mul;
    logic             div;
    logic             load_out;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [COUNT_W-1:0] n_eff;
    logic               is_eval;
    logic               have_next;
  } stat_t;

endpackage

### src/plte_datapath.sv
// Datapath: breakpoint memories, scan, shift-add multiply, restoring divide.
module plte_datapath #(
  parameter int MAX_POINTS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [plte_pkg::COUNT_W-1:0]           cfg_wdata,
  input  logic                                   kind,
  input  logic [plte_pkg::IDX_W-1:0]             entry_index,
  input  logic signed [plte_pkg::DATA_W-1:0]     point_in,
  input  logic signed [plte_pkg::DATA_W-1:0]     point_out,
  input  logic signed [plte_pkg::DATA_W-1:0]     x_value,
  input  plte_pkg::cmd_t                         cmd,
  output plte_pkg::stat_t                        st,
  output logic signed [plte_pkg::DATA_W-1:0]     value,
  output logic [plte_pkg::STATUS_W-1:0]          table_status
);
  import plte_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic [DATA_W-1:0] mem_in  [MAX_POINTS];
  logic [DATA_W-1:0] mem_out [MAX_POINTS];

  logic [COUNT_W-1:0] point_count;
  logic [COUNT_W-1:0] n_used;
  logic [COUNT_W-1:0] n_eff;

  logic                     is_eval;
  logic signed [DATA_W-1:0] x;
  logic signed [DATA_W-1:0] rd_in, rd_out;
  logic signed [DATA_W-1:0] prev_in, seg_in, seg_out, nxt_in, nxt_out;
  logic                     stopped, have_next, order_bad;

  logic [DATA_W-1:0]     span;
  logic [DATA_W-1:0]     mplier;
  logic [2*DATA_W-1:0]   mcand;
  logic [2*DATA_W-1:0]   prod;
  logic [DATA_W-1:0]     rem;
  logic                  neg;

  logic signed [DATA_W:0]   d_span, d_dx, d_step;
  logic [DATA_W:0]          mag;
  logic [DATA_W:0]          trial;
  logic [DATA_W+1:0]        diff;
  logic [DATA_W:0]          quot;
  logic signed [DATA_W+2:0] offset, sum;
  logic signed [DATA_W-1:0] sat;
  logic                     first;

  assign n_used = ({{(32-COUNT_W){1'b0}}, point_count} > MAX_POINTS) ?
                  COUNT_W'(MAX_POINTS) : point_count;
  assign n_eff  = (n_used == '0) ? COUNT_W'(1) : n_used;
  assign first  = (cmd.cnt == CNT_W'(1));

  assign st.n_eff     = n_eff;
  assign st.is_eval   = is_eval;
  assign st.have_next = have_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= COUNT_RESET;
    end else if (cfg_we) begin
      point_count <= cfg_wdata;
    end
  end

  // table storage, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.accept && kind == KIND_LOAD &&
        {{(32-IDX_W){1'b0}}, entry_index} < MAX_POINTS) begin
      mem_in[AW'(entry_index)]  <= point_in;
      mem_out[AW'(entry_index)] <= point_out;
    end
    rd_in  <= mem_in[AW'(cmd.cnt)];
    rd_out <= mem_out[AW'(cmd.cnt)];
  end

  // word capture and segment scan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_eval <= (kind == KIND_EVAL);
      x       <= x_value;
    end
    if (cmd.scan && cmd.cnt != '0) begin
      prev_in <= rd_in;
      if (first) begin
        seg_in    <= rd_in;
        seg_out   <= rd_out;
        stopped   <= (x <= rd_in);
        have_next <= 1'b0;
        order_bad <= 1'b0;
      end else begin
        if (rd_in <= prev_in) order_bad <= 1'b1;
        if (!stopped) begin
          if (x >= rd_in) begin
            seg_in  <= rd_in;
            seg_out <= rd_out;
          end else begin
            stopped   <= 1'b1;
            have_next <= 1'b1;
            nxt_in    <= rd_in;
            nxt_out   <= rd_out;
          end
        end
      end
    end
  end

  assign d_span = {nxt_in[DATA_W-1], nxt_in} - {seg_in[DATA_W-1], seg_in};
  assign d_dx   = {x[DATA_W-1], x} - {seg_in[DATA_W-1], seg_in};
  assign d_step = {nxt_out[DATA_W-1], nxt_out} - {seg_out[DATA_W-1], seg_out};
  assign mag    = d_step[DATA_W] ? (DATA_W+1)'(-d_step) : d_step;

  assign trial = {rem, prod[2*DATA_W-1]};
  assign diff  = {1'b0, trial} - {2'b0, span};

  // multiply then divide, sharing the product register as quotient
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      span   <= d_span[DATA_W-1:0];
      mplier <= d_dx[DATA_W-1:0];
      mcand  <= {{(DATA_W-1){1'b0}}, mag};
      neg    <= d_step[DATA_W];
      prod   <= '0;
      rem    <= '0;
    end else if (cmd.mul) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end else if (cmd.div) begin
      if (!diff[DATA_W+1]) begin
        rem  <= diff[DATA_W-1:0];
        prod <= {prod[2*DATA_W-2:0], 1'b1};
      end else begin
        rem  <= trial[DATA_W-1:0];
        prod <= {prod[2*DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quot   = prod[DATA_W:0];
  assign offset = neg ? -$signed({2'b0, quot}) : $signed({2'b0, quot});
  assign sum    = $signed({{3{seg_out[DATA_W-1]}}, seg_out}) + offset;

  always_comb begin
    priority if (sum > $signed((DATA_W+3)'(33'sh0_7FFF_FFFF))) begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (sum < -$signed((DATA_W+3)'(33'sh0_8000_0000))) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (!is_eval)       value <= '0;
      else if (have_next) value <= sat;
      else                value <= seg_out;
      if (n_used < COUNT_W'(2)) table_status <= STATUS_FEW;
      else if (order_bad)       table_status <= STATUS_ORDER;
      else                      table_status <= STATUS_OK;
    end
  end

endmodule

### src/plte_ctrl.sv
// Controller state machine: sequences scan, multiply, divide and output.
module plte_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  plte_pkg::stat_t st,
  output plte_pkg::cmd_t  cmd
);
  import plte_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cnt_next   = cnt + CNT_W'(1);
    cmd        = '0;
    cmd.cnt    = cnt;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (cnt == CNT_W'(st.n_eff)) state_next = S_PREP;
      end
      S_PREP: begin
        cnt_next = '0;
        if (st.is_eval && st.have_next) begin
          cmd.prep   = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.load_out) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### src/piecewise_linear_table_eval.sv
// Top level of the piecewise-linear breakpoint table evaluator.
//
// Input channel (in_valid / in_stall) carries one word per item: kind 0
// loads breakpoint entry_index with (point_in, point_out); kind 1
// evaluates the table at x_value. Each word gives exactly one result word
// on the output channel (out_valid / out_stall): value (zero for loads)
// and table_status for the table as it stands after the item.
// point_count is written through cfg_we / cfg_wdata while idle; the user
// is bound to that, the block itself does not enforce it. A word is
// accepted only while the controller is idle. The scan makes one memory
// read per point in use, at least one point. An interpolating evaluation
// then adds a shift-add multiply and a restoring divide before its result.
// The result sits in an output register; the next word is taken while it
// waits. If the receiver stalls, a finished result is held in the
// datapath, with the controller waiting, until the output register frees.
// Reset (rst, synchronous) empties the pipeline and sets point_count to
// 2; table contents are undefined until loaded.
module piecewise_linear_table_eval #(
  parameter int MAX_POINTS = plte_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [plte_pkg::COUNT_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [plte_pkg::IDX_W-1:0]          entry_index,
  input  logic signed [plte_pkg::DATA_W-1:0]  point_in,
  input  logic signed [plte_pkg::DATA_W-1:0]  point_out,
  input  logic signed [plte_pkg::DATA_W-1:0]  x_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [plte_pkg::DATA_W-1:0]  value,
  output logic [plte_pkg::STATUS_W-1:0]       table_status
);
  import plte_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencing: idle, scan, operand prep, multiply, divide, hand-off
  plte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // memories, scan registers, arithmetic and the output register
  plte_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .kind         (kind),
    .entry_index  (entry_index),
    .point_in     (point_in),
    .point_out    (point_out),
    .x_value      (x_value),
    .cmd          (cmd),
    .st           (st),
    .value        (value),
    .table_status (table_status)
  );

endmodule

### src/plte_checker.sv
// Port-level assertion checker for the table evaluator, bound to the top.
`include "piecewise_linear_table_eval_assert.svh"

module plte_port_assert (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [plte_pkg::DATA_W-1:0] value,
  input logic [plte_pkg::STATUS_W-1:0]      table_status
);
  import plte_pkg::*;

  // one word in flight: busy right after an accept
  `PLTE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // a new result only appears while the block was working
  `PLTE_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))
  // status code never takes the unused pattern
  `PLTE_ASSERT_NOW(a_status_code, out_valid, table_status != 2'd3)
  // a held result stays put
  `PLTE_ASSERT_NEXT(a_hold, out_valid && out_stall,
                    out_valid && $stable(value) && $stable(table_status))

endmodule

bind piecewise_linear_table_eval plte_port_assert u_plte_port_assert (.*);
